FILE: rtl/core/sivm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivm_pkg: shared definitions for the small key-to-value map
// Sizes, operation and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sivm_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 4;
    localparam int KEY_W    = 16;
    localparam int VAL_W    = 64;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 3;
    localparam int ECNT_W   = 7;

    // Width used to compare a position against the fill count.
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_HAS   = 4'd0,
        OP_ADD   = 4'd1,
        OP_SET   = 4'd2,
        OP_PUT   = 4'd3,
        OP_GET   = 4'd4,
        OP_DROP  = 4'd5,
        OP_AT    = 4'd6,
        OP_COUNT = 4'd7,
        OP_CLEAR = 4'd8
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADPOS   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        KA_SCAN = 2'd0,
        KA_LAST = 2'd1,
        KA_POS  = 2'd2
    } t_ksel;

    typedef enum logic [1:0] {
        VA_SLOT = 2'd0,
        VA_LAST = 2'd1,
        VA_POS  = 2'd2
    } t_vsel;

    typedef struct packed {
        logic    capture;
        logic    scan_en;
        t_ksel   k_sel;
        t_vsel   v_sel;
        logic    take_val;
        logic    take_key;
        logic    wr_append;
        logic    wr_update;
        logic    wr_move;
        logic    occ_clear;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic scan_hit;
        logic scan_miss;
        logic full;
        logic pos_ok;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/core/sivm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivm_in_if: request channel of the key-to-value map
// One beat carries an operation code, a key, a value and a position.
// ----------------------------------------------------------------------------
interface sivm_in_if import sivm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  position;

    modport source (output valid, output operation, output key, output value,
                    output position, input ready);
    modport sink   (input valid, input operation, input key, input value,
                    input position, output ready);
endinterface

FILE: rtl/core/sivm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivm_out_if: response channel of the key-to-value map
// One beat carries the status, the found flag, read data and the count.
// ----------------------------------------------------------------------------
interface sivm_out_if import sivm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              found;
    logic [VAL_W-1:0]  value_out;
    logic [KEY_W-1:0]  key_out;
    logic [ECNT_W-1:0] entry_count;

    modport source (output valid, output status, output found, output value_out,
                    output key_out, output entry_count, input ready);
    modport sink   (input valid, input status, input found, input value_out,
                    input key_out, input entry_count, output ready);
endinterface

FILE: rtl/core/small_id_to_value_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_id_to_value_map: 16-bit key to 64-bit value map
// Unsorted table with swap remove; controller and datapath top level.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | payload
//  i_in     | in  | valid / ready   | operation, key, value, position
//  o_out    | out | valid / ready   | status, found, value_out, key_out, entry_count
//
// One request at a time. From the accepting edge to the edge that loads the response,
// a keyed operation steps through decode, the key scan, memory steps and finish; the scan
// reads one stored key per cycle through the key memory read port. at, count, clear and
// unused codes skip the scan. The next request is taken in the cycle after the response is loaded.
// Reset is synchronous and active low; it empties the table at once.
// A response that is not taken holds the next request in its final step.
// ----------------------------------------------------------------------------
module small_id_to_value_map import sivm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    sivm_in_if.sink    i_in,
    sivm_out_if.source o_out
);

    t_cmd     w_cmd;
    t_dp_stat w_stat;

    sivm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (i_in.ready)
    );

    sivm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_operation   (i_in.operation),
        .i_key         (i_in.key),
        .i_value       (i_in.value),
        .i_position    (i_in.position),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_found       (o_out.found),
        .o_value_out   (o_out.value_out),
        .o_key_out     (o_out.key_out),
        .o_entry_count (o_out.entry_count)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while another is in flight");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found) |-> (o_out.status != ST_NOTFOUND))
        else $error("found key reported as missing");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_FULL)
            |-> (o_out.entry_count == ECNT_W'(CAPACITY)))
        else $error("table full reported below capacity");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_append |-> !w_stat.full)
        else $error("append into a full table");
`endif

endmodule

FILE: rtl/core/sivm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivm_dp: datapath of the key-to-value map
// Key and value memories, fill count, sequential key scan, read capture
// and the response register.
// ----------------------------------------------------------------------------
module sivm_dp import sivm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_dp_stat          o_stat,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [POS_W-1:0]  i_position,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_status,
    output logic              o_found,
    output logic [VAL_W-1:0]  o_value_out,
    output logic [KEY_W-1:0]  o_key_out,
    output logic [ECNT_W-1:0] o_entry_count
);

    logic [KEY_W-1:0]  key_mem [CAPACITY];
    logic [VAL_W-1:0]  val_mem [CAPACITY];

    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_occ, n_occ;
    logic [CNT_W-1:0]  r_idx;
    logic              r_cmp_vld;
    logic [ADDR_W-1:0] r_cmp_idx;
    logic [ADDR_W-1:0] r_slot;
    logic              r_hit;
    t_status           r_stat;
    logic [VAL_W-1:0]  r_vout;
    logic [KEY_W-1:0]  r_kout;
    logic [KEY_W-1:0]  r_kdata;
    logic [VAL_W-1:0]  r_vdata;
    logic              r_out_vld;
    logic [STAT_W-1:0] r_o_status;
    logic              r_o_found;
    logic [VAL_W-1:0]  r_o_value;
    logic [KEY_W-1:0]  r_o_key;
    logic [ECNT_W-1:0] r_o_count;

    logic [ADDR_W-1:0] last_addr;
    logic [ADDR_W-1:0] k_raddr, v_raddr;
    logic [ADDR_W-1:0] wr_addr;
    logic              move_ok;
    logic              k_we, v_we;
    logic [KEY_W-1:0]  k_wdata;
    logic [VAL_W-1:0]  v_wdata;
    logic              hit, issue;

    assign last_addr = ADDR_W'(r_occ - 1'b1);

    // A compare is pending when the previous cycle issued a key read.
    assign hit   = r_cmp_vld && (r_kdata == r_key);
    assign issue = !hit && (r_idx < r_occ);

    assign o_stat.op        = r_op;
    assign o_stat.scan_hit  = hit;
    assign o_stat.scan_miss = !hit && !issue;
    assign o_stat.full      = (r_occ == CNT_W'(CAPACITY));
    assign o_stat.pos_ok    = (CMP_W'(r_pos) < CMP_W'(r_occ));
    assign o_stat.out_free  = !r_out_vld || i_out_ready;

    always_comb begin
        case (i_cmd.k_sel)
            KA_LAST: k_raddr = last_addr;
            KA_POS:  k_raddr = ADDR_W'(r_pos);
            default: k_raddr = r_idx[ADDR_W-1:0];
        endcase
        case (i_cmd.v_sel)
            VA_LAST: v_raddr = last_addr;
            VA_POS:  v_raddr = ADDR_W'(r_pos);
            default: v_raddr = r_slot;
        endcase
    end

    // Swap remove copies the last entry only when the freed slot is not the last.
    assign move_ok = i_cmd.wr_move && (r_slot != last_addr);
    assign wr_addr = i_cmd.wr_append ? ADDR_W'(r_occ) : r_slot;
    assign k_we    = i_cmd.wr_append || move_ok;
    assign v_we    = i_cmd.wr_append || i_cmd.wr_update || move_ok;
    assign k_wdata = i_cmd.wr_append ? r_key : r_kdata;
    assign v_wdata = i_cmd.wr_move ? r_vdata : r_val;

    always_ff @(posedge i_clk) begin
        if (k_we) begin
            key_mem[wr_addr] <= k_wdata;
        end
        r_kdata <= key_mem[k_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            val_mem[wr_addr] <= v_wdata;
        end
        r_vdata <= val_mem[v_raddr];
    end

    always_comb begin
        n_occ = r_occ;
        if (i_cmd.occ_clear) begin
            n_occ = '0;
        end else if (i_cmd.wr_append) begin
            n_occ = r_occ + 1'b1;
        end else if (i_cmd.wr_move) begin
            n_occ = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_occ <= n_occ;
            if (i_cmd.capture) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_en && issue) begin
                r_idx     <= r_idx + 1'b1;
                r_cmp_vld <= 1'b1;
            end else begin
                r_cmp_vld <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_operation);
            r_key  <= i_key;
            r_val  <= i_value;
            r_pos  <= i_position;
            r_hit  <= 1'b0;
            r_stat <= ST_OK;
            r_vout <= '0;
            r_kout <= '0;
        end else begin
            if (i_cmd.scan_en && issue) begin
                r_cmp_idx <= r_idx[ADDR_W-1:0];
            end
            if (i_cmd.scan_en && hit) begin
                r_hit  <= 1'b1;
                r_slot <= r_cmp_idx;
            end
            if (i_cmd.set_status) begin
                r_stat <= i_cmd.status;
            end
            if (i_cmd.take_val) begin
                r_vout <= r_vdata;
            end
            if (i_cmd.take_key) begin
                r_kout <= r_kdata;
            end
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_stat;
            r_o_found  <= r_hit;
            r_o_value  <= r_vout;
            r_o_key    <= r_kout;
            r_o_count  <= ECNT_W'(r_occ);
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_value_out   = r_o_value;
    assign o_key_out     = r_o_key;
    assign o_entry_count = r_o_count;

endmodule

FILE: rtl/core/sivm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivm_ctrl: sequencer of the key-to-value map
// Steps one request through decode, key scan, memory access and response.
// ----------------------------------------------------------------------------
module sivm_ctrl import sivm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd,
    output logic     o_in_ready
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_SCAN   = 9'b000000100,
        S_APPEND = 9'b000001000,
        S_UPDATE = 9'b000010000,
        S_READ   = 9'b000100000,
        S_TAKE   = 9'b001000000,
        S_MOVE   = 9'b010000000,
        S_FINISH = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.k_sel  = KA_SCAN;
        o_cmd.v_sel  = VA_SLOT;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                // Capture in idle is harmless without a beat: decode only starts on accept.
                o_cmd.capture = 1'b1;
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op inside {[OP_HAS:OP_DROP]}) begin
                    n_state = S_SCAN;
                end else if (i_stat.op == OP_AT) begin
                    if (i_stat.pos_ok) begin
                        n_state = S_READ;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_BADPOS;
                        n_state          = S_FINISH;
                    end
                end else begin
                    o_cmd.occ_clear = (i_stat.op == OP_CLEAR);
                    n_state         = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.scan_hit) begin
                    case (i_stat.op)
                        OP_ADD: begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EXISTS;
                            n_state          = S_FINISH;
                        end
                        OP_SET, OP_PUT:  n_state = S_UPDATE;
                        OP_GET, OP_DROP: n_state = S_READ;
                        default:         n_state = S_FINISH;
                    endcase
                end else if (i_stat.scan_miss) begin
                    case (i_stat.op)
                        OP_ADD, OP_SET: begin
                            if (i_stat.full) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = ST_FULL;
                                n_state          = S_FINISH;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                        OP_PUT, OP_GET, OP_DROP: begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NOTFOUND;
                            n_state          = S_FINISH;
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            S_APPEND: begin
                o_cmd.wr_append = 1'b1;
                n_state         = S_FINISH;
            end
            S_UPDATE: begin
                o_cmd.wr_update = 1'b1;
                n_state         = S_FINISH;
            end
            S_READ: begin
                if (i_stat.op == OP_AT) begin
                    o_cmd.k_sel = KA_POS;
                    o_cmd.v_sel = VA_POS;
                end else begin
                    o_cmd.k_sel = KA_LAST;
                    o_cmd.v_sel = VA_SLOT;
                end
                n_state = S_TAKE;
            end
            S_TAKE: begin
                // The last entry is read here so that a drop can move it.
                o_cmd.k_sel    = KA_LAST;
                o_cmd.v_sel    = VA_LAST;
                o_cmd.take_val = 1'b1;
                o_cmd.take_key = (i_stat.op == OP_AT);
                n_state        = (i_stat.op == OP_DROP) ? S_MOVE : S_FINISH;
            end
            S_MOVE: begin
                o_cmd.wr_move = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: tb/sv/sivm_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sivm_map_checker: response checker for the key-to-value map
// Watches the request and response channels. Every accepted request beat is
// applied to a private copy of the table, and the predicted response is
// queued. Every accepted response beat is compared field by field with the
// oldest queued prediction.
// ----------------------------------------------------------------------------
module sivm_map_checker import sivm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sivm_in_if   i_req,
    sivm_out_if  i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_hits
);

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [VAL_W-1:0]  value_out;
        logic [KEY_W-1:0]  key_out;
        logic [ECNT_W-1:0] entry_count;
    } map_resp_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        map_resp_t        resp;
    } due_resp_t;

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];
    int               fill = 0;
    due_resp_t        resp_due_q [$];

    int errors    = 0;
    int pending   = 0;
    int checked   = 0;
    int full_hits = 0;

    assign o_errors    = errors;
    assign o_pending   = pending;
    assign o_checked   = checked;
    assign o_full_hits = full_hits;

    // Applies one request to the shadow table and returns the response it causes.
    function automatic map_resp_t apply_request(input logic [OP_W-1:0] op,
                                                input logic [KEY_W-1:0] key,
                                                input logic [VAL_W-1:0] val,
                                                input logic [POS_W-1:0] pos);
        map_resp_t r;
        int        slot;
        logic      hit;
        r        = '0;
        r.status = ST_OK;
        slot     = 0;
        hit      = 1'b0;
        if (op <= OP_DROP) begin
            for (int i = 0; i < fill; i++) begin
                if (!hit && key_mem[i] == key) begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            r.found = hit;
        end
        case (op)
            OP_ADD, OP_SET: begin
                if (hit && op == OP_ADD) begin
                    r.status = ST_EXISTS;
                end else if (hit) begin
                    val_mem[slot] = val;
                end else if (fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    key_mem[fill] = key;
                    val_mem[fill] = val;
                    fill++;
                end
            end
            OP_PUT: begin
                if (hit) val_mem[slot] = val;
                else r.status = ST_NOTFOUND;
            end
            OP_GET: begin
                if (hit) r.value_out = val_mem[slot];
                else r.status = ST_NOTFOUND;
            end
            OP_DROP: begin
                if (hit) begin
                    // The last entry moves into the freed slot.
                    r.value_out   = val_mem[slot];
                    key_mem[slot] = key_mem[fill-1];
                    val_mem[slot] = val_mem[fill-1];
                    fill--;
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
            OP_AT: begin
                if (int'(pos) < fill) begin
                    r.key_out   = key_mem[pos];
                    r.value_out = val_mem[pos];
                end else begin
                    r.status = ST_BADPOS;
                end
            end
            OP_CLEAR: fill = 0;
            default: ;
        endcase
        r.entry_count = ECNT_W'(fill);
        return r;
    endfunction

    task automatic report(input string what, input due_resp_t want, input map_resp_t got);
        errors++;
        if (errors <= MAX_SHOWN) begin
            $display("[%0t] %s: op=%0d key=%h", $realtime, what, want.op, want.key);
            $display("    expected status=%0d found=%0b value=%h key=%h count=%0d",
                     want.resp.status, want.resp.found, want.resp.value_out,
                     want.resp.key_out, want.resp.entry_count);
            $display("    actual   status=%0d found=%0b value=%h key=%h count=%0d",
                     got.status, got.found, got.value_out, got.key_out, got.entry_count);
        end
    endtask

    always @(posedge i_clk) begin
        due_resp_t want;
        map_resp_t got;
        if (!i_rst_n) begin
            fill = 0;
            resp_due_q.delete();
        end else begin
            // A request is queued before a response is taken off, in case both
            // beats land on the same edge.
            if (i_req.valid && i_req.ready) begin
                want.op   = i_req.operation;
                want.key  = i_req.key;
                want.resp = apply_request(i_req.operation, i_req.key, i_req.value,
                                          i_req.position);
                resp_due_q.push_back(want);
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = {i_rsp.status, i_rsp.found, i_rsp.value_out, i_rsp.key_out,
                       i_rsp.entry_count};
                if (resp_due_q.size() == 0) begin
                    report("response beat with no request outstanding", '0, got);
                end else begin
                    want = resp_due_q.pop_front();
                    checked++;
                    if (want.resp.status == ST_FULL) full_hits++;
                    if (got.status !== want.resp.status || got.found !== want.resp.found
                        || got.value_out !== want.resp.value_out
                        || got.key_out !== want.resp.key_out
                        || got.entry_count !== want.resp.entry_count)
                        report("response mismatch", want, got);
                end
            end
        end
        pending = resp_due_q.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the key-to-value map
// Drives a directed set of requests covering every operation and its missing-key,
// duplicate and bad-position cases, then epochs of random requests that grow, shrink and mix the table
// over a small key pool. The sender works in bursts and the receiver stalls
// in changing patterns, with long hold-offs that back the block up.
// ----------------------------------------------------------------------------
module testbench;
    import sivm_pkg::*;

    localparam int CYCLE_LIMIT  = 900_000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int KEY_POOL     = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int SPARE_OP_LO  = OP_CLEAR + 1;
    localparam int SPARE_OP_HI  = (1 << OP_W) - 1;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    typedef enum int {EP_GROW, EP_SHRINK, EP_MIXED} epoch_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY4, RX_SPARSE} rx_mode_t;

    logic i_clk;
    logic i_rst_n;

    sivm_in_if  in_bus ();
    sivm_out_if out_bus ();

    int errors, pending, checked, full_hits;
    int cycle_cnt = 0;
    int burst_left = 0;
    int op_seen [1 << OP_W];
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    small_id_to_value_map uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    sivm_map_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (in_bus),
        .i_rsp       (out_bus),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_hits (full_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d responses outstanding.",
                     cycle_cnt, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 19) == 0) return KEY_W'($urandom);
        return key_pool[$urandom_range(0, KEY_POOL - 1)];
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input epoch_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            EP_GROW: begin
                if (r < 35) return OP_ADD;
                if (r < 65) return OP_SET;
                if (r < 72) return OP_HAS;
                if (r < 79) return OP_GET;
                if (r < 85) return OP_PUT;
                if (r < 90) return OP_DROP;
                if (r < 97) return OP_AT;
                return OP_COUNT;
            end
            EP_SHRINK: begin
                if (r < 45) return OP_DROP;
                if (r < 58) return OP_GET;
                if (r < 68) return OP_HAS;
                if (r < 78) return OP_AT;
                if (r < 85) return OP_PUT;
                if (r < 92) return OP_ADD;
                if (r < 97) return OP_SET;
                return OP_COUNT;
            end
            default: begin
                if (r < 2) return OP_W'($urandom_range(SPARE_OP_LO, SPARE_OP_HI));
                if (r < 5) return OP_CLEAR;
                return OP_W'($urandom_range(OP_HAS, OP_COUNT));
            end
        endcase
    endfunction

    // Offers one request beat and returns at the falling edge after it is taken.
    task automatic offer(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
        if (burst_left == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        in_bus.valid     <= 1'b1;
        in_bus.operation <= op;
        in_bus.key       <= key;
        in_bus.value     <= val;
        in_bus.position  <= pos;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        op_seen[op]++;
    endtask

    // Receiver: changing stall patterns, with long hold-offs now and then.
    initial begin
        int       seg;
        int       len;
        rx_mode_t mode;
        out_bus.ready = 1'b0;
        seg = 0;
        @(posedge i_rst_n);
        forever begin
            if (seg == 3 || seg % 16 == 11) begin
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                mode = rx_mode_t'($urandom_range(RX_OPEN, RX_SPARSE));
                len  = $urandom_range(30, 250);
                for (int c = 0; c < len; c++) begin
                    case (mode)
                        RX_OPEN:   out_bus.ready <= 1'b1;
                        RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
                        RX_EVERY4: out_bus.ready <= (c % 4 == 3);
                        default:   out_bus.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(negedge i_clk);
                end
            end
            seg++;
        end
    end

    initial begin
        int     work_items;
        int     epoch_len;
        epoch_t mode;
        logic [OP_W-1:0] op;
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.operation = '0;
        in_bus.key       = '0;
        in_bus.value     = '0;
        in_bus.position  = '0;
        foreach (op_seen[i]) op_seen[i] = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom);
        work_items = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty-table misses, inserts at the key extremes, duplicates,
        // updates, reads by position, swap remove, spare codes and clear.
        offer(OP_HAS,   16'h0000, '0, '0);
        offer(OP_GET,   16'h1234, '0, '0);
        offer(OP_PUT,   16'h1234, 64'h0123_4567_89ab_cdef, '0);
        offer(OP_DROP,  16'h1234, '0, '0);
        offer(OP_AT,    16'h0000, '0, 6'd0);
        offer(OP_COUNT, 16'h0000, '0, '0);
        offer(OP_ADD,   16'h0000, '0, '0);
        offer(OP_ADD,   16'hffff, '1, '1);
        offer(OP_ADD,   16'h0000, 64'hdead_beef_cafe_f00d, '0);
        offer(OP_SET,   16'h0000, 64'h8000_0000_0000_0001, '0);
        offer(OP_SET,   16'h5a5a, 64'h5555_aaaa_5555_aaaa, '0);
        offer(OP_PUT,   16'hffff, 64'haaaa_5555_aaaa_5555, '0);
        offer(OP_GET,   16'h0000, '0, '0);
        offer(OP_AT,    16'h0000, '0, 6'd2);
        offer(OP_AT,    16'h0000, '0, '1);
        offer(OP_AT,    16'h0000, '0, 6'd3);
        offer(OP_DROP,  16'h0000, '0, '0);
        offer(OP_AT,    16'h0000, '0, 6'd0);
        offer(OP_DROP,  16'hffff, '0, '0);
        offer(OP_W'(SPARE_OP_LO), 16'h5a5a, '1, '1);
        offer(OP_W'(SPARE_OP_HI), 16'h5a5a, '0, '0);
        offer(OP_ADD,   16'hffff, 64'h0000_0000_ffff_ffff, '0);
        offer(OP_CLEAR, 16'h0000, '0, '0);
        offer(OP_COUNT, 16'h0000, '0, '0);
        offer(OP_GET,   16'hffff, '0, '0);

        while (work_items < RANDOM_ITEMS) begin
            mode      = epoch_t'($urandom_range(EP_GROW, EP_MIXED));
            epoch_len = $urandom_range(80, 200);
            for (int n = 0; n < epoch_len && work_items < RANDOM_ITEMS; n++) begin
                op = pick_op(mode);
                offer(op, pick_key(), pick_value(), POS_W'($urandom_range(0, POS_MAX)));
                if (op <= OP_CLEAR) work_items++;
            end
        end
        in_bus.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d adds, %0d sets, %0d puts, %0d drops, %0d position reads, %0d clears,",
                 op_seen[OP_ADD], op_seen[OP_SET], op_seen[OP_PUT], op_seen[OP_DROP],
                 op_seen[OP_AT], op_seen[OP_CLEAR]);
        $display("%0d responses checked, %0d of them with the table full; %0d mismatches.",
                 checked, full_hits, errors);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sivm_pkg.sv
rtl/core/sivm_in_if.sv
rtl/core/sivm_out_if.sv
rtl/core/sivm_dp.sv
rtl/core/sivm_ctrl.sv
rtl/core/small_id_to_value_map.sv
tb/sv/sivm_map_checker.sv
tb/sv/testbench.sv
